[rtl/core/psr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_pkg: shared constants for the particle shifting repulsion block
// Widths of the fixed fields, the shared arithmetic units and register codes.
// ----------------------------------------------------------------------------
package psr_pkg;

	// Defaults for the top-level parameters.
	localparam int POS_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int CFG_W  = 31;
	localparam int DISP_W = 32;
	localparam int MAG_W  = 31;
	localparam int SUM_W  = 48;

	// Bound below which a reduced sum component must lie (bit index).
	localparam int LIM_W = 31;

	// Shared arithmetic units.
	localparam int RAD_W = 64;
	localparam int MUL_W = 32;
	localparam int NUM_W = 64;
	localparam int DEN_W = 32;

	// Configuration register indexes.
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_ENABLED  = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIN_DIST = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_DISP = 2'd2;

	// Saturation bound of a sum component, one bit wider than the sum.
	localparam logic signed [SUM_W:0] SUM_MAX_EXT = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SUM_MIN_EXT = -SUM_MAX_EXT;

endpackage

[rtl/core/psr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_if: word channels of the particle shifting repulsion block
// Input channel carrying one particle/neighbour pair and output channel
// carrying one displacement result, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface psr_in_if #(
	parameter int POS_WIDTH = psr_pkg::POS_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] own_x;
	logic signed [POS_WIDTH-1:0] own_y;
	logic signed [POS_WIDTH-1:0] own_z;
	logic signed [POS_WIDTH-1:0] nbr_x;
	logic signed [POS_WIDTH-1:0] nbr_y;
	logic signed [POS_WIDTH-1:0] nbr_z;
	logic                        nbr_valid;
	logic                        shiftable;
	logic                        last_nbr;

	modport source (output valid, own_x, own_y, own_z, nbr_x, nbr_y, nbr_z,
		nbr_valid, shiftable, last_nbr, input ready);
	modport sink (input valid, own_x, own_y, own_z, nbr_x, nbr_y, nbr_z,
		nbr_valid, shiftable, last_nbr, output ready);
endinterface

interface psr_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [psr_pkg::DISP_W-1:0]     disp_x;
	logic signed [psr_pkg::DISP_W-1:0]     disp_y;
	logic signed [psr_pkg::DISP_W-1:0]     disp_z;
	logic        [psr_pkg::MAG_W-1:0]      magnitude;
	logic                                  was_clamped;
	logic                                  repulsion_seen;
	logic                                  applied;

	modport source (output valid, disp_x, disp_y, disp_z, magnitude, was_clamped,
		repulsion_seen, applied, input ready);
	modport sink (input valid, disp_x, disp_y, disp_z, magnitude, was_clamped,
		repulsion_seen, applied, output ready);
endinterface

[rtl/core/psr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_div: bit-serial unsigned divider
// Restoring division producing one quotient bit per cycle, most significant
// bit first. Truncates; the remainder is discarded.
// ----------------------------------------------------------------------------
module psr_div #(
	parameter int NUM_W = psr_pkg::NUM_W,
	parameter int DEN_W = psr_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Bring down the next numerator bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// The numerator shifts out at the top while quotient bits shift in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;

endmodule

[rtl/core/psr_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_sqrt: bit-serial integer square root
// Digit-by-digit floor square root: two radicand bits enter and one root bit
// leaves each cycle.
// ----------------------------------------------------------------------------
module psr_sqrt #(
	parameter int RAD_W = psr_pkg::RAD_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAD_W-1:0]   rad,
	output logic               busy,
	output logic [RAD_W/2-1:0] root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W+2:0] trial_rem;
	logic [ROOT_W+2:0] trial_sub;
	logic              fits;

	// Append the next bit pair and test against 4*root + 1.
	always_comb begin
		trial_rem = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial_sub = {1'b0, root_q, 2'b01};
		fits      = trial_rem >= trial_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (ROOT_W+1)'(trial_rem - trial_sub) : trial_rem[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign busy = cnt_q != '0;
	assign root = root_q;

endmodule

[rtl/core/particle_shift_repulsion.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_shift_repulsion: particle shifting by short-range repulsion
// Accumulates a linear repulsion over the neighbours of a particle and emits
// the capped displacement on the last neighbour.
// ----------------------------------------------------------------------------
// Usage. Words enter on item_in, one per particle/neighbour pair, and results
// leave on result_out, one per word flagged last_nbr. The configuration port
// (cfg_we, cfg_idx, cfg_wdata) writes enabled, the repulsion radius or the
// displacement cap, one per write; write it only while the block is idle.
// Operation. One word is worked on at a time by a shift-add multiplier, a
// square root unit and a divider, all one bit per cycle. A word that is
// disabled, invalid or out of range ends without this arithmetic. A neighbour
// in range takes three squares, a root, the strength division and, per
// component, a unit division, a multiply and an add. The last word then halves
// the sum until it fits and finds the length, scaling and magnitude, or emits
// a zero result directly.
// Reset clears the registers, the running sum and the output register.
// Stalls. The result sits in an output register; the next word is taken while
// it waits, and only a further result waits for the register to free.
// ----------------------------------------------------------------------------
module particle_shift_repulsion #(
	parameter int POS_WIDTH = psr_pkg::POS_WIDTH_DEF,
	parameter int FRAC_BITS = psr_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	psr_in_if.sink                          item_in,
	psr_out_if.source                       result_out,
	input  logic                            cfg_we,
	input  logic [psr_pkg::IDX_W-1:0]       cfg_idx,
	input  logic [psr_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int DIFF_W  = POS_WIDTH + 1;
	localparam int CMP_W   = (DIFF_W > psr_pkg::CFG_W) ? DIFF_W : psr_pkg::CFG_W;
	localparam int ROOT_W  = psr_pkg::RAD_W / 2;
	localparam int MCNT_W  = $clog2(psr_pkg::MUL_W + 1);
	localparam int CW      = psr_pkg::CFG_W;
	localparam int SW      = psr_pkg::SUM_W;
	localparam logic [ROOT_W-1:0] ONE_Q = ROOT_W'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_ROOT, S_STR, S_UNIT, S_CMUL, S_ADD,
		S_END, S_RED, S_FMUL, S_FDIV, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_NBR, PH_LEN, PH_MAG} phase_t;

	// Configuration registers.
	logic          en_q;
	logic [CW-1:0] md_q;
	logic [CW-1:0] maxd_q;

	// Sequencer state.
	state_t state_q;
	phase_t phase_q;
	logic [1:0] k_q;
	logic last_q, act_q;

	// Per-word and per-particle data.
	logic [CW-1:0]          dmag_q [3];
	logic                   dneg_q [3];
	logic signed [SW-1:0]   sum_q  [3];
	logic                   flag_q;
	logic [ROOT_W-1:0]      dist_q;
	logic [FRAC_BITS:0]     strength_q;
	logic [FRAC_BITS:0]     unit_q;
	logic [SW-2:0]          cmag_q [3];
	logic                   cneg_q [3];
	logic                   big_q, clamp_q, seen_q;
	logic [CW-1:0]          dispm_q [3];
	logic [psr_pkg::MAG_W-1:0] mag_q;

	// Output register.
	logic                                out_valid_q;
	logic signed [psr_pkg::DISP_W-1:0]   out_disp_q [3];
	logic [psr_pkg::MAG_W-1:0]           out_mag_q;
	logic                                out_clamp_q, out_seen_q, out_applied_q;

	// Shared unit control.
	logic mul_start_q, mul_clr_q, root_start_q, div_start_q;
	logic [psr_pkg::RAD_W-1:0] mul_a_q;
	logic [psr_pkg::MUL_W-1:0] mul_b_q;
	logic [psr_pkg::RAD_W-1:0] mul_acc_q;
	logic [MCNT_W-1:0]         mul_cnt_q;
	logic [psr_pkg::MUL_W-1:0] mul_opa, mul_opb;
	logic                      mul_done, root_done, div_done;
	logic                      root_busy, div_busy;
	logic [ROOT_W-1:0]         root_res;
	logic [psr_pkg::NUM_W-1:0] div_num, div_quot;
	logic [psr_pkg::DEN_W-1:0] div_den;

	// Input differences and the far-neighbour test.
	logic signed [DIFF_W-1:0] diff [3];
	logic [DIFF_W-1:0]        absd [3];
	logic [CMP_W-1:0]         abs_ext [3];
	logic                     far;
	logic                     accept;

	// Contribution of one component and the saturated new sum.
	logic [psr_pkg::RAD_W-1:0] acc_frac;
	logic [FRAC_BITS:0]        contrib_mag;
	logic signed [SW:0]        sum_ext;
	logic signed [SW-1:0]      sum_sat;
	logic                      need_red;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			md_q   <= '0;
			maxd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				psr_pkg::REG_ENABLED:  en_q   <= cfg_wdata[0];
				psr_pkg::REG_MIN_DIST: md_q   <= cfg_wdata;
				psr_pkg::REG_MAX_DISP: maxd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Offsets own - nbr, their magnitudes, and the per-axis range test.
	always_comb begin
		diff[0] = DIFF_W'(item_in.own_x) - DIFF_W'(item_in.nbr_x);
		diff[1] = DIFF_W'(item_in.own_y) - DIFF_W'(item_in.nbr_y);
		diff[2] = DIFF_W'(item_in.own_z) - DIFF_W'(item_in.nbr_z);
		far = 1'b0;
		for (int i = 0; i < 3; i++) begin
			absd[i]    = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
			abs_ext[i] = CMP_W'(absd[i]);
			if (abs_ext[i] >= CMP_W'(md_q))
				far = 1'b1;
		end
	end

	assign accept        = item_in.valid && item_in.ready;
	assign item_in.ready = state_q == S_IDLE;

	// Multiplier operand selection.
	always_comb begin
		mul_opa = '0;
		mul_opb = '0;
		case (state_q)
			S_SQ: begin
				case (phase_q)
					PH_NBR: mul_opa = psr_pkg::MUL_W'(dmag_q[k_q]);
					PH_LEN: mul_opa = psr_pkg::MUL_W'(cmag_q[k_q][CW-1:0]);
					PH_MAG: mul_opa = psr_pkg::MUL_W'(dispm_q[k_q]);
					default: mul_opa = '0;
				endcase
				mul_opb = mul_opa;
			end
			S_CMUL: begin
				mul_opa = psr_pkg::MUL_W'(strength_q);
				mul_opb = psr_pkg::MUL_W'(unit_q);
			end
			S_FMUL: begin
				mul_opa = psr_pkg::MUL_W'(cmag_q[k_q][CW-1:0]);
				mul_opb = psr_pkg::MUL_W'(maxd_q);
			end
			default: ;
		endcase
	end

	// Shift-add multiplier, one multiplier bit per cycle. Squares of the
	// three components accumulate when the clear is withheld.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_a_q   <= '0;
			mul_b_q   <= '0;
			mul_acc_q <= '0;
			mul_cnt_q <= '0;
		end else if (mul_start_q) begin
			mul_a_q   <= psr_pkg::RAD_W'(mul_opa);
			mul_b_q   <= mul_opb;
			mul_cnt_q <= MCNT_W'(psr_pkg::MUL_W);
			if (mul_clr_q)
				mul_acc_q <= '0;
		end else if (mul_cnt_q != '0) begin
			if (mul_b_q[0])
				mul_acc_q <= mul_acc_q + mul_a_q;
			mul_a_q   <= mul_a_q << 1;
			mul_b_q   <= mul_b_q >> 1;
			mul_cnt_q <= mul_cnt_q - 1'b1;
		end
	end

	assign mul_done  = !mul_start_q && mul_cnt_q == '0;
	assign root_done = !root_start_q && !root_busy;
	assign div_done  = !div_start_q && !div_busy;

	psr_sqrt #(
		.RAD_W (psr_pkg::RAD_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start_q),
		.rad    (mul_acc_q),
		.busy   (root_busy),
		.root   (root_res)
	);

	// Divider operand selection.
	always_comb begin
		div_num = '0;
		div_den = '0;
		case (state_q)
			S_STR: begin
				div_num = psr_pkg::NUM_W'(ROOT_W'(md_q) - dist_q) << FRAC_BITS;
				div_den = psr_pkg::DEN_W'(md_q);
			end
			S_UNIT: begin
				div_num = psr_pkg::NUM_W'(dmag_q[k_q]) << FRAC_BITS;
				div_den = psr_pkg::DEN_W'(dist_q + 1'b1);
			end
			S_FDIV: begin
				div_num = mul_acc_q;
				div_den = psr_pkg::DEN_W'(dist_q);
			end
			default: ;
		endcase
	end

	psr_div #(
		.NUM_W (psr_pkg::NUM_W),
		.DEN_W (psr_pkg::DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Signed contribution of the current component, with saturation.
	always_comb begin
		acc_frac    = mul_acc_q >> FRAC_BITS;
		contrib_mag = acc_frac[FRAC_BITS:0];
		sum_ext     = (SW+1)'(sum_q[k_q]) + (dneg_q[k_q] ?
			-(SW+1)'(contrib_mag) : (SW+1)'(contrib_mag));
		if (sum_ext > psr_pkg::SUM_MAX_EXT)
			sum_sat = SW'(psr_pkg::SUM_MAX_EXT);
		else if (sum_ext < psr_pkg::SUM_MIN_EXT)
			sum_sat = SW'(psr_pkg::SUM_MIN_EXT);
		else
			sum_sat = SW'(sum_ext);
		need_red = 1'b0;
		for (int i = 0; i < 3; i++)
			if (cmag_q[i][SW-2:psr_pkg::LIM_W] != '0)
				need_red = 1'b1;
	end

	// Sequencer. The length phase reuses dist_q to hold the vector length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_NBR;
			k_q          <= '0;
			last_q       <= 1'b0;
			act_q        <= 1'b0;
			flag_q       <= 1'b0;
			big_q        <= 1'b0;
			clamp_q      <= 1'b0;
			seen_q       <= 1'b0;
			mag_q        <= '0;
			dist_q       <= '0;
			strength_q   <= '0;
			unit_q       <= '0;
			mul_start_q  <= 1'b0;
			mul_clr_q    <= 1'b0;
			root_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_mag_q    <= '0;
			out_clamp_q  <= 1'b0;
			out_seen_q   <= 1'b0;
			out_applied_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				dmag_q[i]     <= '0;
				dneg_q[i]     <= 1'b0;
				sum_q[i]      <= '0;
				cmag_q[i]     <= '0;
				cneg_q[i]     <= 1'b0;
				dispm_q[i]    <= '0;
				out_disp_q[i] <= '0;
			end
		end else begin
			mul_start_q  <= 1'b0;
			mul_clr_q    <= 1'b0;
			root_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			// The emit state refills the register itself when it is handed over.
			if (out_valid_q && result_out.ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= item_in.last_nbr;
						act_q  <= en_q && item_in.shiftable;
						for (int i = 0; i < 3; i++) begin
							dmag_q[i] <= abs_ext[i][CW-1:0];
							dneg_q[i] <= diff[i][DIFF_W-1];
						end
						if (en_q && item_in.shiftable && item_in.nbr_valid && !far) begin
							phase_q     <= PH_NBR;
							k_q         <= '0;
							mul_start_q <= 1'b1;
							mul_clr_q   <= 1'b1;
							state_q     <= S_SQ;
						end else begin
							state_q <= S_END;
						end
					end
				end
				// Sum of squares, one component after another.
				S_SQ: begin
					if (mul_done) begin
						if (k_q == 2'd2) begin
							k_q          <= '0;
							root_start_q <= 1'b1;
							state_q      <= S_ROOT;
						end else begin
							k_q         <= k_q + 1'b1;
							mul_start_q <= 1'b1;
						end
					end
				end
				S_ROOT: begin
					if (root_done) begin
						case (phase_q)
							PH_NBR: begin
								if (root_res <= ROOT_W'(1) || root_res >= ROOT_W'(md_q)) begin
									state_q <= S_END;
								end else begin
									dist_q      <= root_res;
									div_start_q <= 1'b1;
									state_q     <= S_STR;
								end
							end
							PH_LEN: begin
								dist_q      <= root_res;
								clamp_q     <= maxd_q != '0 && (big_q || root_res > ONE_Q);
								k_q         <= '0;
								mul_start_q <= 1'b1;
								mul_clr_q   <= 1'b1;
								state_q     <= S_FMUL;
							end
							default: begin
								mag_q <= root_res[ROOT_W-1] ? {psr_pkg::MAG_W{1'b1}} :
									root_res[psr_pkg::MAG_W-1:0];
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				// Strength of the repulsion.
				S_STR: begin
					if (div_done) begin
						strength_q  <= div_quot[FRAC_BITS:0];
						k_q         <= '0;
						div_start_q <= 1'b1;
						state_q     <= S_UNIT;
					end
				end
				// Unit offset component.
				S_UNIT: begin
					if (div_done) begin
						unit_q      <= div_quot[FRAC_BITS:0];
						mul_start_q <= 1'b1;
						mul_clr_q   <= 1'b1;
						state_q     <= S_CMUL;
					end
				end
				S_CMUL: begin
					if (mul_done)
						state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q[k_q] <= sum_sat;
					if (k_q == 2'd2) begin
						flag_q  <= 1'b1;
						state_q <= S_END;
					end else begin
						k_q         <= k_q + 1'b1;
						div_start_q <= 1'b1;
						state_q     <= S_UNIT;
					end
				end
				// End of one word; on the last neighbour start the final pass.
				S_END: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (act_q && flag_q) begin
						seen_q <= 1'b1;
						big_q  <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							cmag_q[i] <= sum_q[i][SW-1] ? (SW-1)'(-sum_q[i]) :
								sum_q[i][SW-2:0];
							cneg_q[i] <= sum_q[i][SW-1];
						end
						state_q <= S_RED;
					end else begin
						seen_q  <= 1'b0;
						clamp_q <= 1'b0;
						mag_q   <= '0;
						for (int i = 0; i < 3; i++) begin
							dispm_q[i] <= '0;
							cneg_q[i]  <= 1'b0;
						end
						state_q <= S_EMIT;
					end
				end
				// Halve a huge sum until every component fits.
				S_RED: begin
					if (need_red) begin
						big_q <= 1'b1;
						for (int i = 0; i < 3; i++)
							cmag_q[i] <= cmag_q[i] >> 1;
					end else begin
						phase_q     <= PH_LEN;
						k_q         <= '0;
						mul_start_q <= 1'b1;
						mul_clr_q   <= 1'b1;
						state_q     <= S_SQ;
					end
				end
				// Scale by the displacement cap, then divide by the length if capped.
				S_FMUL: begin
					if (mul_done) begin
						if (clamp_q) begin
							div_start_q <= 1'b1;
							state_q     <= S_FDIV;
						end else begin
							dispm_q[k_q] <= acc_frac[CW-1:0];
							mul_start_q  <= 1'b1;
							mul_clr_q    <= 1'b1;
							if (k_q == 2'd2) begin
								k_q     <= '0;
								phase_q <= PH_MAG;
								state_q <= S_SQ;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
					end
				end
				S_FDIV: begin
					if (div_done) begin
						dispm_q[k_q] <= div_quot[CW-1:0];
						mul_start_q  <= 1'b1;
						mul_clr_q    <= 1'b1;
						if (k_q == 2'd2) begin
							k_q     <= '0;
							phase_q <= PH_MAG;
							state_q <= S_SQ;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_FMUL;
						end
					end
				end
				// Hand the result to the output register and clear the sum.
				S_EMIT: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q   <= 1'b1;
						out_mag_q     <= mag_q;
						out_clamp_q   <= clamp_q;
						out_seen_q    <= seen_q;
						out_applied_q <= en_q;
						for (int i = 0; i < 3; i++) begin
							out_disp_q[i] <= cneg_q[i] ?
								-psr_pkg::DISP_W'(dispm_q[i]) : psr_pkg::DISP_W'(dispm_q[i]);
							sum_q[i] <= '0;
						end
						flag_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.disp_x         = out_disp_q[0];
	assign result_out.disp_y         = out_disp_q[1];
	assign result_out.disp_z         = out_disp_q[2];
	assign result_out.magnitude      = out_mag_q;
	assign result_out.was_clamped    = out_clamp_q;
	assign result_out.repulsion_seen = out_seen_q;
	assign result_out.applied        = out_applied_q;

	// A word is only taken with every arithmetic unit at rest.
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.ready |-> (!root_busy && !div_busy && mul_cnt_q == '0))
		else $error("word accepted while an arithmetic unit is busy");

	// A capped result always comes from a repulsion.
	a_clamp_seen: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (!result_out.was_clamped || result_out.repulsion_seen))
		else $error("capped result without repulsion");

	// A result without repulsion carries no displacement.
	a_zero_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.repulsion_seen) |->
		(result_out.disp_x == '0 && result_out.disp_y == '0 &&
		result_out.disp_z == '0 && result_out.magnitude == '0))
		else $error("displacement without repulsion");

	// The running sum is cleared once a result is handed over.
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!out_valid_q || result_out.ready)) |=>
		(!flag_q && sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0))
		else $error("running sum not cleared after a result");

endmodule

[sim/particle_shift_repulsion_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_shift_repulsion_tb: self-checking bench for the repulsion block
// Sends particle/neighbour words under random idling on both channels,
// predicts each displacement word in fixed point, and compares every result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module particle_shift_repulsion_tb;

	localparam longint ONE_Q   = 64'sd1 << 16;
	localparam longint SUM_LIM = (64'sd1 << 47) - 1;
	localparam longint LIM31   = 64'sd1 << 31;
	localparam longint CYCLE_LIMIT = 64'd20000000;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [30:0]        mag;
		logic               clamped;
		logic               seen;
		logic               applied;
	} disp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [psr_pkg::IDX_W-1:0] cfg_idx = psr_pkg::REG_ENABLED;
	logic [psr_pkg::CFG_W-1:0] cfg_wdata = '0;

	psr_in_if  item_in();
	psr_out_if result_out();

	particle_shift_repulsion dut (
		.clk(clk), .arst_n(arst_n), .item_in(item_in), .result_out(result_out),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Predictor state and configuration.
	logic         shift_on;
	longint       radius;
	longint       disp_cap;
	longint       sum_acc[3];
	logic         near_seen;
	disp_word_t   pending_disp[$];
	int           failures = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	bit           hold_recv = 1'b0;
	longint       cycles = 0;

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Adds the repulsion of one neighbour to the running sum.
	task automatic add_repulsion(longint d[3]);
		longint unsigned sq;
		longint sep, strength, unit, s;
		sq = 0;
		for (int k = 0; k < 3; k++)
			if (mag_of(d[k]) >= radius) return;
		for (int k = 0; k < 3; k++) sq += longint'(d[k] * d[k]);
		sep = root_floor(sq);
		if (sep <= 1 || sep >= radius) return;
		strength = ((radius - sep) * ONE_Q) / radius;
		for (int k = 0; k < 3; k++) begin
			unit = (d[k] * ONE_Q) / (sep + 1);
			s = sum_acc[k] + (strength * unit) / ONE_Q;
			if (s > SUM_LIM) s = SUM_LIM;
			if (s < -SUM_LIM) s = -SUM_LIM;
			sum_acc[k] = s;
		end
		near_seen = 1'b1;
	endtask

	// Updates the running sum for one word and queues the displacement it ends.
	task automatic predict_displacement(logic signed [31:0] own[3],
			logic signed [31:0] nbr[3], logic nv, logic sh, logic last);
		longint d[3], c[3], disp[3], len;
		longint unsigned sq, m;
		logic active, big, fits;
		disp_word_t w;
		active = shift_on && sh;
		w = '0;
		if (active && nv) begin
			for (int k = 0; k < 3; k++) d[k] = longint'(own[k]) - longint'(nbr[k]);
			add_repulsion(d);
		end
		if (!last) return;
		if (active && near_seen) begin
			w.seen = 1'b1;
			big = 1'b0;
			for (int k = 0; k < 3; k++) c[k] = sum_acc[k];
			forever begin
				fits = 1'b1;
				for (int k = 0; k < 3; k++) if (mag_of(c[k]) >= LIM31) fits = 1'b0;
				if (fits) break;
				big = 1'b1;
				for (int k = 0; k < 3; k++)
					c[k] = c[k] < 0 ? -(mag_of(c[k]) >>> 1) : (c[k] >>> 1);
			end
			sq = 0;
			for (int k = 0; k < 3; k++) sq += longint'(c[k] * c[k]);
			len = root_floor(sq);
			if (disp_cap > 0 && (big || len > ONE_Q)) begin
				w.clamped = 1'b1;
				for (int k = 0; k < 3; k++) disp[k] = (c[k] * disp_cap) / len;
			end else begin
				for (int k = 0; k < 3; k++) disp[k] = (c[k] * disp_cap) / ONE_Q;
			end
			sq = 0;
			for (int k = 0; k < 3; k++) sq += longint'(disp[k] * disp[k]);
			m = longint'(root_floor(sq));
			if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
			w.dx = disp[0][31:0];
			w.dy = disp[1][31:0];
			w.dz = disp[2][31:0];
			w.mag = m[30:0];
		end
		w.applied = shift_on;
		pending_disp.push_back(w);
		for (int k = 0; k < 3; k++) sum_acc[k] = 0;
		near_seen = 1'b0;
	endtask

	// Sends one word and predicts its effect once accepted.
	task automatic send_word(logic signed [31:0] own[3], logic signed [31:0] nbr[3],
			logic nv, logic sh, logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		item_in.valid <= 1'b1;
		item_in.own_x <= own[0];
		item_in.own_y <= own[1];
		item_in.own_z <= own[2];
		item_in.nbr_x <= nbr[0];
		item_in.nbr_y <= nbr[1];
		item_in.nbr_z <= nbr[2];
		item_in.nbr_valid <= nv;
		item_in.shiftable <= sh;
		item_in.last_nbr <= last;
		do @(posedge clk); while (!item_in.ready);
		predict_displacement(own, nbr, nv, sh, last);
		@(negedge clk);
		item_in.valid <= 1'b0;
	endtask

	// Writes one register once the block has drained.
	task automatic write_reg(logic [psr_pkg::IDX_W-1:0] idx,
			logic [psr_pkg::CFG_W-1:0] val);
		while (pending_disp.size() != 0) @(negedge clk);
		repeat (1500) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			psr_pkg::REG_ENABLED:  shift_on = val[0];
			psr_pkg::REG_MIN_DIST: radius = longint'(val);
			default:               disp_cap = longint'(val);
		endcase
	endtask

	task automatic configure(logic en, longint md, longint mx);
		write_reg(psr_pkg::REG_ENABLED, psr_pkg::CFG_W'(en));
		write_reg(psr_pkg::REG_MIN_DIST, psr_pkg::CFG_W'(md));
		write_reg(psr_pkg::REG_MAX_DISP, psr_pkg::CFG_W'(mx));
	endtask

	// One particle with n neighbours at random offsets within the given spread.
	task automatic send_particle(logic signed [31:0] own[3], int n, longint spread,
			logic sh, bit noisy);
		logic signed [31:0] nbr[3];
		longint off;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				off = longint'($urandom_range(32'(2 * spread))) - spread;
				nbr[k] = (noisy && $urandom_range(9) == 0) ? $urandom :
					32'(longint'(own[k]) - off);
			end
			send_word(own, nbr, noisy ? $urandom_range(7) != 0 : 1'b1, sh, i == n - 1);
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		disp_word_t got, want;
		cycles <= cycles + 1;
		if (result_out.valid && result_out.ready) begin
			got = '{result_out.disp_x, result_out.disp_y, result_out.disp_z,
				result_out.magnitude, result_out.was_clamped, result_out.repulsion_seen,
				result_out.applied};
			if (pending_disp.size() == 0) begin
				$error("unexpected displacement word");
				failures++;
			end else begin
				want = pending_disp.pop_front();
				if (got.dx !== want.dx) begin
					$error("disp_x expected %0d got %0d", want.dx, got.dx); failures++;
				end
				if (got.dy !== want.dy) begin
					$error("disp_y expected %0d got %0d", want.dy, got.dy); failures++;
				end
				if (got.dz !== want.dz) begin
					$error("disp_z expected %0d got %0d", want.dz, got.dz); failures++;
				end
				if (got.mag !== want.mag) begin
					$error("magnitude expected %0d got %0d", want.mag, got.mag); failures++;
				end
				if (got.clamped !== want.clamped) begin
					$error("was_clamped expected %0b got %0b", want.clamped, got.clamped);
					failures++;
				end
				if (got.seen !== want.seen) begin
					$error("repulsion_seen expected %0b got %0b", want.seen, got.seen);
					failures++;
				end
				if (got.applied !== want.applied) begin
					$error("applied expected %0b got %0b", want.applied, got.applied);
					failures++;
				end
			end
		end
	end

	// Receiver ready, with random idling and a long hold-off on request.
	always @(negedge clk) begin
		result_out.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
	end

	// Cycle limit.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Directed: extremes, disabled, not shiftable, invalid, far, zero cap.
	task automatic test_directed();
		logic signed [31:0] own[3], nbr[3];
		own = '{32'sd0, 32'sd0, 32'sd0};
		nbr = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd5};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		configure(1'b1, 64'sd4 << 16, 64'sd1 << 16);
		nbr = '{32'sd65536, 32'sd0, 32'sd0};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		send_word(own, nbr, 1'b1, 1'b0, 1'b1);
		send_word(own, nbr, 1'b0, 1'b1, 1'b1);
		nbr = '{32'sd1, 32'sd0, 32'sd0};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		nbr = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		own = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		own = '{32'sd0, 32'sd0, 32'sd0};
		nbr = '{32'sd30000, -32'sd20000, 32'sd100};
		send_word(own, nbr, 1'b1, 1'b1, 1'b0);
		send_word(own, nbr, 1'b1, 1'b1, 1'b0);
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
		configure(1'b1, 64'h7FFFFFFF, 64'h7FFFFFFF);
		nbr = '{32'sh40000000, 32'sh40000000, -32'sh3FFFFFFF};
		for (int i = 0; i < 6; i++) send_word(own, nbr, 1'b1, 1'b1, i == 5);
		configure(1'b1, 64'sd8 << 16, 64'sd0);
		nbr = '{32'sd70000, 32'sd10, -32'sd5};
		send_word(own, nbr, 1'b1, 1'b1, 1'b1);
	endtask

	// Random particles, mostly clustered within the radius.
	task automatic test_random(int n_items);
		logic signed [31:0] own[3];
		int sent, n;
		longint spread;
		sent = 0;
		while (sent < n_items) begin
			for (int k = 0; k < 3; k++) own[k] = $urandom;
			n = $urandom_range(1, 6);
			case ($urandom_range(3))
				0: spread = radius + 2;
				1: spread = 64'sd1 << $urandom_range(0, 30);
				default: spread = radius / 2 + 1;
			endcase
			send_particle(own, n, spread, $urandom_range(9) != 0, $urandom_range(4) == 0);
			sent += n;
		end
	endtask

	// Receiver stalls for a long time while words keep coming.
	task automatic test_backpressure();
		logic signed [31:0] own[3];
		own = '{32'sd0, 32'sd0, 32'sd0};
		fork
			begin
				hold_recv = 1'b1;
				repeat (8000) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 8; i++) send_particle(own, 1, radius / 2 + 1, 1'b1, 1'b0);
		join
	endtask

	initial begin
		item_in.valid = 1'b0;
		item_in.own_x = '0;
		item_in.own_y = '0;
		item_in.own_z = '0;
		item_in.nbr_x = '0;
		item_in.nbr_y = '0;
		item_in.nbr_z = '0;
		item_in.nbr_valid = 1'b0;
		item_in.shiftable = 1'b0;
		item_in.last_nbr = 1'b0;
		result_out.ready = 1'b0;
		shift_on = 1'b0;
		radius = 0;
		disp_cap = 0;
		for (int k = 0; k < 3; k++) sum_acc[k] = 0;
		near_seen = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		send_idle_pct = 38;
		recv_idle_pct = 56;
		configure(1'b1, 64'sd3 << 16, 64'sd1 << 15);
		test_random(500);
		test_backpressure();
		send_idle_pct = 56;
		recv_idle_pct = 38;
		configure(1'b1, 64'sd200, 64'sd50 << 16);
		test_random(500);
		configure(1'b0, 64'sd3 << 16, 64'sd1 << 16);
		test_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(1'b1, 64'sd1 << 20, 64'sd1 << 12);
		test_random(600);
		while (pending_disp.size() != 0) @(negedge clk);
		repeat (1500) @(negedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
